// File: hdl/aat_pkg.sv
// Package: command, status and class codes shared by the translation table modules.
package aat_pkg;

    localparam int unsigned DEF_ENTRIES_46 = 64;
    localparam int unsigned DEF_ENTRIES_66 = 64;

    localparam logic [2:0] CMD_CLEAR    = 3'd0;
    localparam logic [2:0] CMD_INS46    = 3'd1;
    localparam logic [2:0] CMD_INS66    = 3'd2;
    localparam logic [2:0] CMD_X4TO6    = 3'd3;
    localparam logic [2:0] CMD_X6TO4    = 3'd4;
    localparam logic [2:0] CMD_X6TO6    = 3'd5;
    localparam logic [2:0] CMD_CLASSIFY = 3'd6;

    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_NOT_FOUND = 3'd1;
    localparam logic [2:0] ST_AMBIGUOUS = 3'd2;
    localparam logic [2:0] ST_DUPLICATE = 3'd3;
    localparam logic [2:0] ST_FULL      = 3'd4;

    localparam logic [1:0] TC_NONE = 2'd0;
    localparam logic [1:0] TC_66   = 2'd1;
    localparam logic [1:0] TC_64   = 2'd2;

    localparam logic [1:0] CFG_PREFIX_UPPER  = 2'd0;
    localparam logic [1:0] CFG_PREFIX_MIDDLE = 2'd1;

    // Hits gathered by one scan of both tables
    typedef struct packed {
        logic         h4v4;   // v4 key (first or second) hit in 46 table
        logic         h4v6;   // first v6 hit in 46 table
        logic         hs66;   // first v6 hit in 66 table
        logic         hd66;   // second v6 hit in 66 table
        logic [31:0]  v4_val; // v4 of the first v6 hit
        logic [63:0]  v6_hi;
        logic [63:0]  v6_lo;
        logic [63:0]  s_hi;
        logic [63:0]  s_lo;
        logic [63:0]  d_hi;
        logic [63:0]  d_lo;
    } scan_res_t;

endpackage

// File: hdl/aat_scan.sv
// Scan unit: holds both tables and compares one entry of each per cycle.
module aat_scan #(
    parameter int unsigned ENTRIES_46 = aat_pkg::DEF_ENTRIES_46,
    parameter int unsigned ENTRIES_66 = aat_pkg::DEF_ENTRIES_66
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                clr,
    input  logic                scan_start,
    input  logic [31:0]         key_v4,
    input  logic [63:0]         key_a_hi,
    input  logic [63:0]         key_a_lo,
    input  logic [63:0]         key_b_hi,
    input  logic [63:0]         key_b_lo,
    input  logic                wr46,
    input  logic                wr66,
    output logic                done,
    output logic                free46,
    output logic                free66,
    output aat_pkg::scan_res_t  res
);
    localparam int unsigned N    = (ENTRIES_46 > ENTRIES_66) ? ENTRIES_46 : ENTRIES_66;
    localparam int unsigned IW46 = (ENTRIES_46 > 1) ? $clog2(ENTRIES_46) : 1;
    localparam int unsigned IW66 = (ENTRIES_66 > 1) ? $clog2(ENTRIES_66) : 1;
    localparam int unsigned CW   = $clog2(N + 2);

    logic [31:0] m4_v4 [ENTRIES_46];
    logic [63:0] m4_hi [ENTRIES_46];
    logic [63:0] m4_lo [ENTRIES_46];
    logic [63:0] pa_hi [ENTRIES_66];
    logic [63:0] pa_lo [ENTRIES_66];
    logic [63:0] pb_hi [ENTRIES_66];
    logic [63:0] pb_lo [ENTRIES_66];
    logic [ENTRIES_46-1:0] used46_reg;
    logic [ENTRIES_66-1:0] used66_reg;

    logic [CW-1:0]   cnt_reg;      // address presented to memories
    logic            run_reg;      // read issued
    logic            vld_reg;      // read data valid this cycle
    logic [CW-1:0]   rcnt_reg;     // address of read data
    logic            last_reg;
    logic [IW46-1:0] slot46_reg;
    logic [IW66-1:0] slot66_reg;
    logic            f46_reg, f66_reg;

    logic [31:0] r4_v4;
    logic [63:0] r4_hi, r4_lo, ra_hi, ra_lo, rb_hi, rb_lo;
    logic        u46, u66;
    aat_pkg::scan_res_t res_reg, res_next;

    // Registered memory reads and writes at the free slot
    always_ff @(posedge clk)
    begin
        if (cnt_reg < CW'(ENTRIES_46))
        begin
            r4_v4 <= m4_v4[cnt_reg[IW46-1:0]];
            r4_hi <= m4_hi[cnt_reg[IW46-1:0]];
            r4_lo <= m4_lo[cnt_reg[IW46-1:0]];
        end
        if (cnt_reg < CW'(ENTRIES_66))
        begin
            ra_hi <= pa_hi[cnt_reg[IW66-1:0]];
            ra_lo <= pa_lo[cnt_reg[IW66-1:0]];
            rb_hi <= pb_hi[cnt_reg[IW66-1:0]];
            rb_lo <= pb_lo[cnt_reg[IW66-1:0]];
        end
        if (wr46)
        begin
            m4_v4[slot46_reg] <= key_v4;
            m4_hi[slot46_reg] <= key_a_hi;
            m4_lo[slot46_reg] <= key_a_lo;
        end
        if (wr66)
        begin
            pa_hi[slot66_reg] <= key_a_hi;
            pa_lo[slot66_reg] <= key_a_lo;
            pb_hi[slot66_reg] <= key_b_hi;
            pb_lo[slot66_reg] <= key_b_lo;
        end
    end

    assign u46 = (rcnt_reg < CW'(ENTRIES_46)) && used46_reg[rcnt_reg[IW46-1:0]];
    assign u66 = (rcnt_reg < CW'(ENTRIES_66)) && used66_reg[rcnt_reg[IW66-1:0]];

    // Compare the entry read back; first hit wins
    always_comb
    begin
        res_next = scan_start ? '0 : res_reg;
        if (vld_reg)
        begin
            if (u46 && !res_reg.h4v4 && r4_v4 == key_v4)
            begin
                res_next.h4v4   = 1'b1;
                res_next.v6_hi  = r4_hi;
                res_next.v6_lo  = r4_lo;
            end
            if (u46 && !res_reg.h4v6 && r4_hi == key_a_hi && r4_lo == key_a_lo)
            begin
                res_next.h4v6   = 1'b1;
                res_next.v4_val = r4_v4;
            end
            if (u66 && !res_reg.hs66)
            begin
                if (ra_hi == key_a_hi && ra_lo == key_a_lo)
                begin
                    res_next.hs66 = 1'b1;
                    res_next.s_hi = rb_hi;
                    res_next.s_lo = rb_lo;
                end
                else if (rb_hi == key_a_hi && rb_lo == key_a_lo)
                begin
                    res_next.hs66 = 1'b1;
                    res_next.s_hi = ra_hi;
                    res_next.s_lo = ra_lo;
                end
            end
            if (u66 && !res_reg.hd66)
            begin
                if (ra_hi == key_b_hi && ra_lo == key_b_lo)
                begin
                    res_next.hd66 = 1'b1;
                    res_next.d_hi = rb_hi;
                    res_next.d_lo = rb_lo;
                end
                else if (rb_hi == key_b_hi && rb_lo == key_b_lo)
                begin
                    res_next.hd66 = 1'b1;
                    res_next.d_hi = ra_hi;
                    res_next.d_lo = ra_lo;
                end
            end
        end
    end

    // Sequencing, valid bits and lowest free slot
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            used46_reg <= '0;
            used66_reg <= '0;
            cnt_reg    <= '0;
            run_reg    <= 1'b0;
            vld_reg    <= 1'b0;
            rcnt_reg   <= '0;
            last_reg   <= 1'b0;
            slot46_reg <= '0;
            slot66_reg <= '0;
            f46_reg    <= 1'b0;
            f66_reg    <= 1'b0;
            res_reg    <= '0;
        end
        else
        begin
            res_reg  <= res_next;
            vld_reg  <= run_reg;
            rcnt_reg <= cnt_reg;
            last_reg <= run_reg && (cnt_reg == CW'(N - 1));
            if (clr)
            begin
                used46_reg <= '0;
                used66_reg <= '0;
            end
            if (wr46)
                used46_reg[slot46_reg] <= 1'b1;
            if (wr66)
                used66_reg[slot66_reg] <= 1'b1;
            if (scan_start)
            begin
                cnt_reg <= '0;
                run_reg <= 1'b1;
                f46_reg <= 1'b0;
                f66_reg <= 1'b0;
            end
            else if (run_reg)
            begin
                if (cnt_reg == CW'(N - 1))
                    run_reg <= 1'b0;
                else
                    cnt_reg <= cnt_reg + 1'b1;
            end
            if (vld_reg && !f46_reg && (rcnt_reg < CW'(ENTRIES_46)) && !u46)
            begin
                f46_reg    <= 1'b1;
                slot46_reg <= rcnt_reg[IW46-1:0];
            end
            if (vld_reg && !f66_reg && (rcnt_reg < CW'(ENTRIES_66)) && !u66)
            begin
                f66_reg    <= 1'b1;
                slot66_reg <= rcnt_reg[IW66-1:0];
            end
        end
    end

    assign done   = last_reg;
    assign res    = res_reg;
    assign free46 = f46_reg;
    assign free66 = f66_reg;

    a_wr_free46: assert property (@(posedge clk) disable iff (!rst_n) wr46 |-> f46_reg)
        else $error("46 write without a free slot");
    a_wr_free66: assert property (@(posedge clk) disable iff (!rst_n) wr66 |-> f66_reg)
        else $error("66 write without a free slot");
    a_done_one: assert property (@(posedge clk) disable iff (!rst_n) done |=> !done)
        else $error("scan done held");
endmodule

// File: hdl/ipv4_ipv6_address_translation_table.sv
// Top level: command sequencer, prefix registers and result formatting.
//
// Usage: present a command beat with start high while busy is low; every
// input field is sampled at that edge. The block then scans both tables,
// one entry of each per cycle through a single compare unit, and
// answers with exactly one result beat marked by done for one cycle.
// Every command, clear and inserts included, runs the full scan over
// the entries before done rises. busy is high from acceptance until done
// rises and is low in the done cycle, so the next command can be taken
// at the edge that ends the done cycle; the block takes no new command
// while one is in flight. Config writes (cfg_we, cfg_index, cfg_data)
// take effect at the edge; the user must make them only while the block
// is idle, which the block itself does not enforce. An index beyond the
// two prefix registers is ignored.
// Reset clears all valid bits, prefixes and the sequencer; entry
// contents are left as they are. Result beats cannot be stalled: the
// receiver must take each one in its done cycle.
module ipv4_ipv6_address_translation_table #(
    parameter int unsigned ENTRIES_46 = aat_pkg::DEF_ENTRIES_46,
    parameter int unsigned ENTRIES_66 = aat_pkg::DEF_ENTRIES_66
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [63:0] cfg_data,
    input  logic        start,
    output logic        busy,
    input  logic [2:0]  cmd,
    input  logic [31:0] v4_first,
    input  logic [31:0] v4_second,
    input  logic [63:0] v6_first_hi,
    input  logic [63:0] v6_first_lo,
    input  logic [63:0] v6_second_hi,
    input  logic [63:0] v6_second_lo,
    output logic        done,
    output logic [2:0]  status,
    output logic [1:0]  traffic_class,
    output logic [31:0] v4_src_out,
    output logic [31:0] v4_dst_out,
    output logic [63:0] v6_src_out_hi,
    output logic [63:0] v6_src_out_lo,
    output logic [63:0] v6_dst_out_hi,
    output logic [63:0] v6_dst_out_lo
);
    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_SCAN = 2'd1;
    localparam logic [1:0] S_OUT  = 2'd2;

    logic [1:0]  state_reg;
    logic [63:0] pu_reg;
    logic [31:0] pm_reg;
    logic [2:0]  cmd_reg;
    logic [31:0] v4a_reg, v4b_reg, key_v4;
    logic [63:0] ahi_reg, alo_reg, bhi_reg, blo_reg;
    logic        accept, scan_done, free46, free66, wr46, wr66, clr;
    logic        scan_start_reg;
    aat_pkg::scan_res_t sres;

    logic        done_reg;
    logic [2:0]  st_reg;
    logic [1:0]  tc_reg;
    logic [31:0] o4s_reg, o4d_reg;
    logic [63:0] osh_reg, osl_reg, odh_reg, odl_reg;
    logic [2:0]  st_next;
    logic [1:0]  tc_next;
    logic [31:0] o4s_next, o4d_next;
    logic [63:0] osh_next, osl_next, odh_next, odl_next;

    assign accept = start && !busy;
    assign busy   = (state_reg != S_IDLE);
    assign key_v4 = (cmd_reg == aat_pkg::CMD_X4TO6) ? v4b_reg : v4a_reg;

    // Capture command and operand fields
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg <= cmd;
            v4a_reg <= v4_first;
            v4b_reg <= v4_second;
            ahi_reg <= v6_first_hi;
            alo_reg <= v6_first_lo;
            bhi_reg <= v6_second_hi;
            blo_reg <= v6_second_lo;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pu_reg <= '0;
            pm_reg <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                aat_pkg::CFG_PREFIX_UPPER:  pu_reg <= cfg_data;
                aat_pkg::CFG_PREFIX_MIDDLE: pm_reg <= cfg_data[31:0];
                default: ;
            endcase
        end
    end

    aat_scan #(.ENTRIES_46(ENTRIES_46), .ENTRIES_66(ENTRIES_66)) u_scan (
        .clk(clk), .rst_n(rst_n), .clr(clr), .scan_start(scan_start_reg),
        .key_v4(key_v4), .key_a_hi(ahi_reg), .key_a_lo(alo_reg),
        .key_b_hi(bhi_reg), .key_b_lo(blo_reg), .wr46(wr46), .wr66(wr66),
        .done(scan_done), .free46(free46), .free66(free66), .res(sres)
    );

    // Decide result, table writes and clear once the scan is over
    always_comb
    begin
        st_next  = aat_pkg::ST_OK;
        tc_next  = aat_pkg::TC_NONE;
        o4s_next = '0;
        o4d_next = '0;
        osh_next = '0;
        osl_next = '0;
        odh_next = '0;
        odl_next = '0;
        wr46     = 1'b0;
        wr66     = 1'b0;
        clr      = 1'b0;
        if (state_reg == S_OUT)
        begin
            case (cmd_reg)
                aat_pkg::CMD_CLEAR: clr = 1'b1;
                aat_pkg::CMD_INS46:
                begin
                    if (sres.h4v4 || sres.h4v6)
                        st_next = aat_pkg::ST_DUPLICATE;
                    else if (!free46)
                        st_next = aat_pkg::ST_FULL;
                    else
                        wr46 = 1'b1;
                end
                aat_pkg::CMD_INS66:
                begin
                    if (sres.hs66 || sres.hd66)
                        st_next = aat_pkg::ST_DUPLICATE;
                    else if (!free66)
                        st_next = aat_pkg::ST_FULL;
                    else
                        wr66 = 1'b1;
                end
                aat_pkg::CMD_X4TO6:
                begin
                    if (!sres.h4v4)
                        st_next = aat_pkg::ST_NOT_FOUND;
                    else
                    begin
                        osh_next = pu_reg;
                        osl_next = {pm_reg, v4a_reg};
                        odh_next = sres.v6_hi;
                        odl_next = sres.v6_lo;
                    end
                end
                aat_pkg::CMD_X6TO4:
                begin
                    if (!sres.h4v6)
                        st_next = aat_pkg::ST_NOT_FOUND;
                    else
                    begin
                        o4s_next = sres.v4_val;
                        o4d_next = blo_reg[31:0];
                    end
                end
                aat_pkg::CMD_X6TO6:
                begin
                    if (sres.hs66 && sres.hd66)
                        st_next = aat_pkg::ST_AMBIGUOUS;
                    else if (!sres.hs66 && !sres.hd66)
                        st_next = aat_pkg::ST_NOT_FOUND;
                    else if (sres.hs66)
                    begin
                        osh_next = sres.s_hi;
                        osl_next = sres.s_lo;
                        odh_next = bhi_reg;
                        odl_next = blo_reg;
                    end
                    else
                    begin
                        osh_next = ahi_reg;
                        osl_next = alo_reg;
                        odh_next = sres.d_hi;
                        odl_next = sres.d_lo;
                    end
                end
                aat_pkg::CMD_CLASSIFY:
                begin
                    if (!sres.hs66 && sres.hd66 && !sres.h4v6)
                        tc_next = aat_pkg::TC_66;
                    else if ((sres.hs66 || sres.h4v6) && !sres.hd66)
                        tc_next = (bhi_reg == pu_reg) ? aat_pkg::TC_64 : aat_pkg::TC_66;
                end
                default: ;
            endcase
        end
    end

    // Sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            scan_start_reg <= 1'b0;
            done_reg       <= 1'b0;
        end
        else
        begin
            scan_start_reg <= accept;
            done_reg       <= (state_reg == S_OUT);
            unique case (state_reg)
                S_IDLE: if (accept) state_reg <= S_SCAN;
                S_SCAN: if (scan_done) state_reg <= S_OUT;
                S_OUT:  state_reg <= S_IDLE;
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == S_OUT)
        begin
            st_reg  <= st_next;
            tc_reg  <= tc_next;
            o4s_reg <= o4s_next;
            o4d_reg <= o4d_next;
            osh_reg <= osh_next;
            osl_reg <= osl_next;
            odh_reg <= odh_next;
            odl_reg <= odl_next;
        end
    end

    assign done          = done_reg;
    assign status        = st_reg;
    assign traffic_class = tc_reg;
    assign v4_src_out    = o4s_reg;
    assign v4_dst_out    = o4d_reg;
    assign v6_src_out_hi = osh_reg;
    assign v6_src_out_lo = osl_reg;
    assign v6_dst_out_hi = odh_reg;
    assign v6_dst_out_lo = odl_reg;

    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n) done |-> !busy)
        else $error("done outside idle");
    a_out_once: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_OUT |=> state_reg == S_IDLE && done)
        else $error("result beat missing");
    a_scan_busy: assert property (@(posedge clk) disable iff (!rst_n) accept |=> busy)
        else $error("busy not raised");
endmodule
